### rtl/irswf_pkg.sv
// ----------------------------------------------------------------------------
// irswf_pkg: shared types and constants of the IR detector window filter
// Channel state codes, direction codes, register map and config bundle.
// ----------------------------------------------------------------------------
package irswf_pkg;

	localparam int WINDOW_DEF = 8;
	localparam int NUM_CH     = 4;
	localparam int THR_W      = 4;
	localparam int TICK_W     = 8;
	localparam int RUN_W      = 16;
	localparam int ADDR_W     = 4;
	localparam int DATA_W     = 32;

	localparam logic [THR_W-1:0]  VOTE_RST  = 4'd5;
	localparam logic [TICK_W-1:0] TICK_RST  = 8'd10;
	localparam logic [RUN_W-1:0]  LIMIT_RST = 16'd2000;

	typedef enum logic [1:0] {
		ST_INACTIVE  = 2'd0,
		ST_ACTIVE    = 2'd1,
		ST_SATURATED = 2'd2
	} ch_state_t;

	typedef enum logic [3:0] {
		DIR_NONE      = 4'd0,
		DIR_CENTER    = 4'd1,
		DIR_UP        = 4'd2,
		DIR_DOWN      = 4'd3,
		DIR_LEFT      = 4'd4,
		DIR_RIGHT     = 4'd5,
		DIR_UPLEFT    = 4'd6,
		DIR_UPRIGHT   = 4'd7,
		DIR_DOWNLEFT  = 4'd8,
		DIR_DOWNRIGHT = 4'd9
	} dir_t;

	typedef enum logic [1:0] {
		REG_VOTE  = 2'd0,
		REG_TICK  = 2'd1,
		REG_LIMIT = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		CH_TOP    = 2'd0,
		CH_BOTTOM = 2'd1,
		CH_LEFT   = 2'd2,
		CH_RIGHT  = 2'd3
	} ch_idx_t;

	typedef struct packed {
		logic [THR_W-1:0]  vote_threshold;
		logic [TICK_W-1:0] tick_period_ms;
		logic [RUN_W-1:0]  saturation_limit_ms;
	} cfg_t;

endpackage

### rtl/irswf_in_if.sv
// ----------------------------------------------------------------------------
// irswf_in_if: sample channel
// One transfer carries the four active-low detector levels of one tick.
// ----------------------------------------------------------------------------
interface irswf_in_if;
	logic valid;
	logic ready;
	logic top_level;
	logic bottom_level;
	logic left_level;
	logic right_level;

	modport source (output valid, top_level, bottom_level, left_level, right_level,
		input ready);
	modport sink (input valid, top_level, bottom_level, left_level, right_level,
		output ready);
endinterface

### rtl/irswf_out_if.sv
// ----------------------------------------------------------------------------
// irswf_out_if: result channel
// One transfer carries the four channel states and the decoded direction.
// ----------------------------------------------------------------------------
interface irswf_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] top_state;
	logic [1:0] bottom_state;
	logic [1:0] left_state;
	logic [1:0] right_state;
	logic [3:0] direction;

	modport source (output valid, top_state, bottom_state, left_state, right_state,
		direction, input ready);
	modport sink (input valid, top_state, bottom_state, left_state, right_state,
		direction, output ready);
endinterface

### rtl/irswf_lane.sv
// ----------------------------------------------------------------------------
// irswf_lane: one detector channel
// Sample ring, vote count, saturating run counter and saturation flag.
// ----------------------------------------------------------------------------
module irswf_lane #(
	parameter int WINDOW = irswf_pkg::WINDOW_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  det,
	input  irswf_pkg::cfg_t       cfg,
	output irswf_pkg::ch_state_t  state
);
	import irswf_pkg::*;

	localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);

	logic [WINDOW-1:0] win_q, win_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [RUN_W-1:0]  run_q, run_d;
	logic              sat_q, sat_d;
	logic [RUN_W:0]    run_sum;
	logic [THR_W-1:0]  ones;

	always_comb begin
		win_d = win_q;
		win_d[pos_q] = det;
		pos_d = (pos_q == POS_LAST) ? '0 : pos_q + 1'b1;
		run_sum = {1'b0, run_q} + {{(RUN_W + 1 - TICK_W){1'b0}}, cfg.tick_period_ms};
		if (!det) begin
			run_d = '0;
			sat_d = 1'b0;
		end else begin
			run_d = run_sum[RUN_W] ? {RUN_W{1'b1}} : run_sum[RUN_W-1:0];
			sat_d = sat_q || (run_d >= cfg.saturation_limit_ms);
		end
	end

	// vote count over the window after this tick's sample
	always_comb begin
		ones = '0;
		for (int i = 0; i < WINDOW; i++) begin
			ones = ones + THR_W'(win_d[i]);
		end
	end

	always_comb begin
		if (sat_d) begin
			state = ST_SATURATED;
		end else if (ones >= cfg.vote_threshold) begin
			state = ST_ACTIVE;
		end else begin
			state = ST_INACTIVE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			pos_q <= '0;
			run_q <= '0;
			sat_q <= 1'b0;
		end else if (adv) begin
			win_q <= win_d;
			pos_q <= pos_d;
			run_q <= run_d;
			sat_q <= sat_d;
		end
	end
endmodule

### rtl/irswf_merge.sv
// ----------------------------------------------------------------------------
// irswf_merge: direction decode and result register
// Combines the lane states into a direction and holds the result transfer.
// ----------------------------------------------------------------------------
module irswf_merge (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  irswf_pkg::ch_state_t  st [irswf_pkg::NUM_CH],
	irswf_out_if.source           result
);
	import irswf_pkg::*;

	logic u, d, l, r;
	logic h_neg, h_pos, v_neg, v_pos;
	dir_t dir;
	logic valid_q;

	assign u = (st[CH_TOP]    == ST_ACTIVE);
	assign d = (st[CH_BOTTOM] == ST_ACTIVE);
	assign l = (st[CH_LEFT]   == ST_ACTIVE);
	assign r = (st[CH_RIGHT]  == ST_ACTIVE);

	// opposite channels both active cancel to the centered component
	assign h_neg = l && !r;
	assign h_pos = r && !l;
	assign v_neg = u && !d;
	assign v_pos = d && !u;

	always_comb begin
		if (!(u || d || l || r)) begin
			dir = DIR_NONE;
		end else if (h_neg) begin
			dir = v_neg ? DIR_UPLEFT : (v_pos ? DIR_DOWNLEFT : DIR_LEFT);
		end else if (h_pos) begin
			dir = v_neg ? DIR_UPRIGHT : (v_pos ? DIR_DOWNRIGHT : DIR_RIGHT);
		end else begin
			dir = v_neg ? DIR_UP : (v_pos ? DIR_DOWN : DIR_CENTER);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result.top_state    <= st[CH_TOP];
			result.bottom_state <= st[CH_BOTTOM];
			result.left_state   <= st[CH_LEFT];
			result.right_state  <= st[CH_RIGHT];
			result.direction    <= dir;
		end
	end

	assign result.valid = valid_q;
endmodule

### rtl/ir_sensor_window_filter_direction_unit.sv
// ----------------------------------------------------------------------------
// ir_sensor_window_filter_direction_unit: four-channel detector filter
// Window vote, run-time saturation and compass direction of four detectors.
// ----------------------------------------------------------------------------
// Usage:
//   sample : valid/ready channel, one transfer per tick with the four
//            active-low detector levels (0 = signal seen).
//   result : valid/ready channel, one transfer per sample: a state per
//            channel (inactive, active, saturated) and a direction code.
//   APB    : three registers at byte offsets 0, 4, 8 (vote threshold, tick
//            period, saturation limit); write while the block is idle.
// Timing: a result is registered and valid in the cycle after its sample transfer.
// Throughput: one sample per cycle while results are taken. The four lanes update in the accept
//   cycle and the merge stage registers the result, so the result register
//   is the only stage; it refills in the same cycle it is drained.
// Reset: windows, run counters and flags clear, registers take their
//   defaults, the result register is empty.
// Stall: while a result waits, sample ready drops; nothing is lost.
// ----------------------------------------------------------------------------
module ir_sensor_window_filter_direction_unit #(
	parameter int WINDOW = irswf_pkg::WINDOW_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	irswf_in_if.sink                       sample,
	irswf_out_if.source                    result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [irswf_pkg::ADDR_W-1:0]   paddr,
	input  logic [irswf_pkg::DATA_W-1:0]   pwdata,
	output logic [irswf_pkg::DATA_W-1:0]   prdata,
	output logic                           pready
);
	import irswf_pkg::*;

	cfg_t      cfg_q;
	logic      accept;
	logic      cfg_wr;
	reg_idx_t  reg_sel;
	logic      det [NUM_CH];
	ch_state_t st  [NUM_CH];

	// ---------------- configuration registers ----------------
	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vote_threshold      <= VOTE_RST;
			cfg_q.tick_period_ms      <= TICK_RST;
			cfg_q.saturation_limit_ms <= LIMIT_RST;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_VOTE:  cfg_q.vote_threshold      <= pwdata[THR_W-1:0];
				REG_TICK:  cfg_q.tick_period_ms      <= pwdata[TICK_W-1:0];
				REG_LIMIT: cfg_q.saturation_limit_ms <= pwdata[RUN_W-1:0];
				default: ;  // unmapped offset: write dropped
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_VOTE:  prdata = {{(DATA_W - THR_W){1'b0}}, cfg_q.vote_threshold};
			REG_TICK:  prdata = {{(DATA_W - TICK_W){1'b0}}, cfg_q.tick_period_ms};
			REG_LIMIT: prdata = {{(DATA_W - RUN_W){1'b0}}, cfg_q.saturation_limit_ms};
			default:   prdata = '0;
		endcase
	end

	// ---------------- sample handshake ----------------
	// Accept whenever the result register is empty or being drained now.
	assign sample.ready = !result.valid || result.ready;
	assign accept       = sample.valid && sample.ready;

	// Detectors are active low.
	assign det[CH_TOP]    = !sample.top_level;
	assign det[CH_BOTTOM] = !sample.bottom_level;
	assign det[CH_LEFT]   = !sample.left_level;
	assign det[CH_RIGHT]  = !sample.right_level;

	// ---------------- per-channel lanes ----------------
	for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
		irswf_lane #(
			.WINDOW (WINDOW)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (accept),
			.det    (det[c]),
			.cfg    (cfg_q),
			.state  (st[c])
		);
	end

	// ---------------- direction merge and result register ----------------
	irswf_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (accept),
		.st     (st),
		.result (result)
	);

`ifndef NO_ASSERTIONS
	// every accepted sample shows up as a result in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> result.valid)
		else $error("result missing after sample transfer");

	// direction is none exactly when no channel reports active
	a_dir_none: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> ((result.direction == DIR_NONE) ==
			((result.top_state != ST_ACTIVE) && (result.bottom_state != ST_ACTIVE) &&
			 (result.left_state != ST_ACTIVE) && (result.right_state != ST_ACTIVE))))
		else $error("direction disagrees with channel states");

	// an idle top detector sample can never leave the top channel saturated
	a_top_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && sample.top_level) |=> (result.top_state != ST_SATURATED))
		else $error("top channel saturated on an idle sample");

	// no sample is taken while an undrained result is held
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |-> !accept)
		else $error("sample taken over a stalled result");
`endif
endmodule
